// ===== hw/rtl/pfr_pkg.sv =====
// Package for the page framebuffer refresh block.
// Holds the beat types, store geometry and command codes; no dependencies.
package pfr_pkg;

  localparam int unsigned MaxColumns = 132;
  localparam int unsigned MaxPages   = 8;
  localparam int unsigned StoreDepth = MaxColumns * MaxPages;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [7:0] PageCmd    = 8'hB0;
  localparam logic [7:0] ColHighCmd = 8'h10;
  localparam logic [7:0] ColLowCmd  = 8'h00;

  localparam logic OpDraw    = 1'b0;
  localparam logic OpRefresh = 1'b1;

  localparam logic [1:0] ModeSet    = 2'd0;
  localparam logic [1:0] ModeClear  = 2'd1;
  localparam logic [1:0] ModeInvert = 2'd2;
  localparam logic [1:0] ModeKeep   = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgColumnCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPageCount   = CfgIdxW'(1);

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_x;
    logic [5:0] pixel_y;
    logic [1:0] draw_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       frame_end;
  } out_item_t;

endpackage

// ===== hw/rtl/page_framebuffer_refresh.sv =====
// Page framebuffer with panel refresh stream: top level.
// Depends on pfr_pkg; holds the pixel store memory and the refresh sequencer.
//
// After reset the block clears all MaxColumns * MaxPages bytes of its pixel store,
// one byte per cycle; busy_o is high during that pass and start_i is ignored.
// Afterwards busy_o stays low and one item is taken every cycle. Each item does one
// read of the pixel store, which has a read and a write port, and a draw writes the
// modified byte back in the next cycle; a draw followed at once by an access to the
// same byte is served by forwarding. A refresh item puts its byte on result_o, with
// result_valid_o high for one cycle, after the stage-1 and result registers; draws
// give no result. The result cannot be held off, so collect it on that cycle. Write
// configuration only while no refresh item is still on its way to the output.
module page_framebuffer_refresh (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  pfr_pkg::in_item_t             item_i,
  output logic                          result_valid_o,
  output pfr_pkg::out_item_t            result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pfr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pfr_pkg::*;

  typedef enum logic [1:0] {
    PhPage,
    PhColHigh,
    PhColLow,
    PhData
  } phase_e;

  logic [7:0] mem_q [StoreDepth];
  logic [7:0] rdata_q;

  logic             clearing_q;
  logic [AddrW-1:0] clr_cnt_q;

  logic [7:0] cols_cfg_q;
  logic [3:0] pages_cfg_q;
  logic [7:0] cols;
  logic [3:0] pages;

  logic [2:0] page_q, page_d;
  logic [7:0] col_q, col_d;
  phase_e     phase_q, phase_d;

  logic       accept;
  logic       draw_ok;
  logic [AddrW-1:0] draw_addr;
  logic [AddrW-1:0] ref_addr;
  logic [AddrW-1:0] raddr;
  logic [2:0] pg;
  logic [7:0] col;
  phase_e     ph;
  logic [8:0] col_inc;
  logic [7:0] cmd_byte;
  logic       is_cmd;
  logic       frame_end;

  logic             s1_valid_q;
  logic             s1_refresh_q;
  logic             s1_we_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [7:0]       s1_mask_q;
  logic [1:0]       s1_mode_q;
  logic [7:0]       s1_cmd_q;
  logic             s1_is_cmd_q;
  logic             s1_frame_end_q;

  logic       fwd_q;
  logic [7:0] fwd_data_q;
  logic [7:0] cur_byte;
  logic [7:0] new_byte;

  logic             res_valid_q;
  out_item_t        res_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  assign busy_o         = clearing_q;
  assign cfg_ready_o    = 1'b1;
  assign accept         = start_i && !clearing_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    if (cols_cfg_q == 8'd0) begin
      cols = 8'd1;
    end else if (cols_cfg_q > 8'(MaxColumns)) begin
      cols = 8'(MaxColumns);
    end else begin
      cols = cols_cfg_q;
    end
    if (pages_cfg_q == 4'd0) begin
      pages = 4'd1;
    end else if (pages_cfg_q > 4'(MaxPages)) begin
      pages = 4'(MaxPages);
    end else begin
      pages = pages_cfg_q;
    end
  end

  assign draw_ok   = (item_i.pixel_x < cols) && ({1'b0, item_i.pixel_y[5:3]} < pages);
  assign draw_addr = AddrW'(cols) * AddrW'(item_i.pixel_y[5:3]) + AddrW'(item_i.pixel_x);

  always_comb begin
    pg = page_q;
    col = col_q;
    ph = phase_q;
    if ({1'b0, pg} >= pages) begin
      pg = 3'd0;
      col = 8'd0;
      ph = PhPage;
    end
    if (col >= cols) begin
      col = 8'd0;
    end
    col_inc   = {1'b0, col} + 9'd1;
    ref_addr  = AddrW'(cols) * AddrW'(pg) + AddrW'(col);
    frame_end = 1'b0;
    is_cmd    = 1'b1;
    cmd_byte  = ColLowCmd;
    page_d    = page_q;
    col_d     = col_q;
    phase_d   = phase_q;
    unique case (ph)
      PhPage: begin
        cmd_byte = PageCmd | {5'd0, pg};
        phase_d  = PhColHigh;
      end
      PhColHigh: begin
        cmd_byte = ColHighCmd;
        phase_d  = PhColLow;
      end
      PhColLow: begin
        cmd_byte = ColLowCmd;
        phase_d  = PhData;
      end
      PhData: begin
        is_cmd = 1'b0;
        phase_d = PhData;
      end
      default: begin
        phase_d = PhPage;
      end
    endcase
    page_d = pg;
    col_d  = col;
    if (ph == PhData) begin
      if (col_inc >= {1'b0, cols}) begin
        col_d   = 8'd0;
        phase_d = PhPage;
        if ({1'b0, pg} + 4'd1 >= pages) begin
          page_d    = 3'd0;
          frame_end = 1'b1;
        end else begin
          page_d = pg + 3'd1;
        end
      end else begin
        col_d = col_inc[7:0];
      end
    end
  end

  assign raddr = (item_i.opcode == OpRefresh) ? ref_addr : draw_addr;

  assign cur_byte = fwd_q ? fwd_data_q : rdata_q;

  always_comb begin
    case (s1_mode_q)
      ModeSet:    new_byte = cur_byte | s1_mask_q;
      ModeClear:  new_byte = cur_byte & ~s1_mask_q;
      ModeInvert: new_byte = cur_byte ^ s1_mask_q;
      default:    new_byte = cur_byte;
    endcase
  end

  assign mem_we    = clearing_q || s1_we_q;
  assign mem_waddr = clearing_q ? clr_cnt_q : s1_addr_q;
  assign mem_wdata = clearing_q ? 8'd0 : new_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q      <= raddr;
    s1_mask_q      <= 8'd1 << item_i.pixel_y[2:0];
    s1_mode_q      <= item_i.draw_mode;
    s1_cmd_q       <= cmd_byte;
    s1_is_cmd_q    <= is_cmd;
    s1_frame_end_q <= frame_end;
    fwd_data_q     <= new_byte;
    res_q.out_byte   <= s1_is_cmd_q ? s1_cmd_q : cur_byte;
    res_q.is_command <= s1_is_cmd_q;
    res_q.frame_end  <= s1_frame_end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q   <= 1'b1;
      clr_cnt_q    <= '0;
      cols_cfg_q   <= 8'd128;
      pages_cfg_q  <= 4'd8;
      page_q       <= 3'd0;
      col_q        <= 8'd0;
      phase_q      <= PhPage;
      s1_valid_q   <= 1'b0;
      s1_refresh_q <= 1'b0;
      s1_we_q      <= 1'b0;
      fwd_q        <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(StoreDepth - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      s1_valid_q   <= accept;
      s1_refresh_q <= accept && (item_i.opcode == OpRefresh);
      s1_we_q      <= accept && (item_i.opcode == OpDraw) && draw_ok &&
                      (item_i.draw_mode != ModeKeep);
      fwd_q        <= s1_we_q && (s1_addr_q == raddr);
      res_valid_q  <= s1_valid_q && s1_refresh_q;
      if (accept && (item_i.opcode == OpRefresh)) begin
        page_q  <= page_d;
        col_q   <= col_d;
        phase_q <= phase_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgColumnCount: begin
            cols_cfg_q <= cfg_data_i;
            page_q     <= 3'd0;
            col_q      <= 8'd0;
            phase_q    <= PhPage;
          end
          CfgPageCount: begin
            pages_cfg_q <= cfg_data_i[3:0];
            page_q      <= 3'd0;
            col_q       <= 8'd0;
            phase_q     <= PhPage;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_refresh_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.opcode == OpRefresh) |-> ##2 result_valid_o)
    else $error("refresh beat produced no result");

  a_draw_gives_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.opcode == OpDraw) |-> ##2 !result_valid_o)
    else $error("draw beat produced a result");

  a_frame_end_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.frame_end |-> !result_o.is_command)
    else $error("frame end marked on a command byte");

  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_we_q && !s1_valid_q)
    else $error("item in flight during clearing pass");

  a_fwd_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(s1_we_q))
    else $error("forwarding without a preceding write");

endmodule
